// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/ecal_pkg.sv
// Shared types, constants and calendar helpers for the epoch-to-calendar block
package ecal_pkg;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV_DAY,
    OP_SET_HOUR,
    OP_DIV_HOUR,
    OP_SET_MIN,
    OP_DIV_MIN,
    OP_SET_YEAR,
    OP_YEAR,
    OP_SET_MONTH,
    OP_MONTH,
    OP_CAPTURE
  } op_t;

  // loop exit flags from the datapath
  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // constant divides as q = (x * RECIP) >> shift, exact over the x range used
  localparam logic [9:0]  DAY_ODD       = 10'd675;       // 86400 = 675 << 7
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;  // ceil(2^35 / 675), x < 2^25
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [13:0] HOUR_RECIP    = 14'd9321;      // ceil(2^21 / 225), x = tod >> 4
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [10:0] MIN_RECIP     = 11'd1093;      // ceil(2^14 / 15), x = rem >> 2
  localparam logic [16:0] WEEK_RECIP    = 17'd74899;     // ceil(2^19 / 7), x < 2^16

  localparam logic [3:0] DAYS_PER_WEEK  = 4'd7;
  localparam logic [3:0] WEEKDAY_DAY0   = 4'd4;   // 1970-01-01 was a Thursday
  localparam logic [7:0] FIRST_YOFF     = 8'd70;  // 1970 - 1900
  localparam logic [7:0] NONLEAP_CENT   = 8'd200; // 2100 - 1900
  localparam logic [3:0] LAST_MONTH     = 4'd11;

  // Gregorian leap rule over 1970..2106: every fourth year except 2100
  function automatic logic is_leap(input logic [7:0] yoff);
    is_leap = (yoff[1:0] == 2'b00) && (yoff != NONLEAP_CENT);
  endfunction

  // month length in days
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    case (mon)
      4'd1:                      month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

endpackage

// File: design/epoch_seconds_to_calendar.sv
// Top level: epoch seconds to broken-down UTC calendar time
//
// Input channel: in_valid/in_ready carry one word, epoch_seconds, unsigned
// seconds since 1970-01-01 00:00:00 UTC. Output channel: out_valid/out_ready
// carry one word of second, minute, hour, weekday, years_since_1900,
// day_of_year, month_index and day_of_month. One output word per input word.
// After a word is accepted, six steps split the seconds into days, time of
// day, weekday, hours and minutes by reciprocal multiplication; then one year
// is subtracted per cycle, over the whole years since 1970 (0..136), and one
// month per cycle up to the month index (0..11), with a setup step for the
// month loop between the two loops and a capture step at the end.
// One word is in flight at a time; once the result is loaded the controller
// returns to idle and can take a new word.
// The result sits in its own output register, so the next word is accepted
// and worked on while a stalled receiver holds the last one; the block waits
// at the end of a conversion only if the output register is still full.
// Reset (rst, synchronous) returns the controller to idle and drops out_valid.
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month
);

  ecal_pkg::op_t     op;
  ecal_pkg::status_t status;

  ecal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  ecal_dp u_dp (
    .clk              (clk),
    .op               (op),
    .epoch_seconds    (epoch_seconds),
    .status           (status),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .weekday          (weekday),
    .years_since_1900 (years_since_1900),
    .day_of_year      (day_of_year),
    .month_index      (month_index),
    .day_of_month     (day_of_month)
  );

  // a taken word starts a conversion, so the input closes at once
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input open after accept")
  // a new result only follows a capture command
  `ASSERT_IMP(a_valid_from_capture, clk, rst, $rose(out_valid), $past(op == ecal_pkg::OP_CAPTURE), "result without capture")
  // presented fields stay in calendar range
  `ASSERT_IMP(a_result_range, clk, rst, out_valid, (month_index <= 4'd11) && (day_of_month != 5'd0) && (hour <= 5'd23) && (weekday <= 3'd6), "result out of range")

endmodule

// File: design/ecal_ctrl.sv
// Controller state machine sequencing the divide, year and month loops
module ecal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ecal_pkg::status_t status,
  output ecal_pkg::op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE, S_DAY, S_HSET, S_HOUR, S_MSET, S_MIN,
    S_YSET, S_YEAR, S_MOSET, S_MONTH, S_DONE
  } state_t;

  state_t state;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // command decode
  always_comb begin
    case (state)
      S_IDLE:  op = in_valid ? ecal_pkg::OP_LOAD : ecal_pkg::OP_IDLE;
      S_DAY:   op = ecal_pkg::OP_DIV_DAY;
      S_HSET:  op = ecal_pkg::OP_SET_HOUR;
      S_HOUR:  op = ecal_pkg::OP_DIV_HOUR;
      S_MSET:  op = ecal_pkg::OP_SET_MIN;
      S_MIN:   op = ecal_pkg::OP_DIV_MIN;
      S_YSET:  op = ecal_pkg::OP_SET_YEAR;
      S_YEAR:  op = ecal_pkg::OP_YEAR;
      S_MOSET: op = ecal_pkg::OP_SET_MONTH;
      S_MONTH: op = ecal_pkg::OP_MONTH;
      S_DONE:  op = out_free ? ecal_pkg::OP_CAPTURE : ecal_pkg::OP_IDLE;
      default: op = ecal_pkg::OP_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise on capture, drop once the word is taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DAY;
        end
        S_DAY:   state <= S_HSET;
        S_HSET:  state <= S_HOUR;
        S_HOUR:  state <= S_MSET;
        S_MSET:  state <= S_MIN;
        S_MIN:   state <= S_YSET;
        S_YSET:  state <= S_YEAR;
        S_YEAR: begin
          if (status.year_done) state <= S_MOSET;
        end
        S_MOSET: state <= S_MONTH;
        S_MONTH: begin
          if (status.month_done) state <= S_DONE;
        end
        S_DONE: begin
          // wait until the output register is free
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/ecal_dp.sv
// Datapath: reciprocal-multiply dividers, weekday residue, year and month subtractors
module ecal_dp (
  input  logic              clk,
  input  ecal_pkg::op_t     op,
  input  logic [31:0]       epoch_seconds,
  output ecal_pkg::status_t status,
  output logic [5:0]        second,
  output logic [5:0]        minute,
  output logic [4:0]        hour,
  output logic [2:0]        weekday,
  output logic [7:0]        years_since_1900,
  output logic [8:0]        day_of_year,
  output logic [3:0]        month_index,
  output logic [4:0]        day_of_month
);

  // working registers
  logic [16:0] rem;
  logic [31:0] acc;
  logic [15:0] days;
  logic [13:0] wq;
  logic [7:0]  yoff;
  logic [3:0]  mon;
  logic [8:0]  yday;
  logic [4:0]  hr;
  logic [5:0]  mn;
  logic [5:0]  sc;
  logic [2:0]  wd;

  logic [50:0] day_prod;
  logic [24:0] day_back;
  logic [24:0] tod_hi;
  logic [15:0] wsum;
  logic [32:0] wq_prod;
  logic [15:0] wback;
  logic [15:0] wrem;
  logic [26:0] hr_prod;
  logic [16:0] hback;
  logic [20:0] mn_prod;
  logic [11:0] mback;
  logic [11:0] sdiff;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // days = (secs >> 7) / 675; time of day from the remainder and the low bits
  assign day_prod = {26'b0, acc[31:7]} * {25'b0, ecal_pkg::DAY_RECIP};
  assign day_back = {9'b0, days} * {15'b0, ecal_pkg::DAY_ODD};
  assign tod_hi   = acc[31:7] - day_back;

  // weekday = (days + 4) mod 7
  assign wsum    = days + {12'b0, ecal_pkg::WEEKDAY_DAY0};
  assign wq_prod = {17'b0, wsum} * {16'b0, ecal_pkg::WEEK_RECIP};
  assign wback   = {2'b0, wq} * {12'b0, ecal_pkg::DAYS_PER_WEEK};
  assign wrem    = wsum - wback;

  // hours = (tod >> 4) / 225, minutes = (rem >> 2) / 15
  assign hr_prod = {14'b0, rem[16:4]} * {13'b0, ecal_pkg::HOUR_RECIP};
  assign hback   = {12'b0, hr} * {5'b0, ecal_pkg::SECS_PER_HOUR};
  assign mn_prod = {11'b0, rem[11:2]} * {10'b0, ecal_pkg::MIN_RECIP};
  assign mback   = {6'b0, mn} * {6'b0, ecal_pkg::SECS_PER_MIN};
  assign sdiff   = rem[11:0] - mback;

  // year and month lengths
  assign leap = ecal_pkg::is_leap(yoff);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = ecal_pkg::month_len(leap, mon);

  assign status.year_done  = (days < {7'b0, ylen});
  assign status.month_done = (mon == ecal_pkg::LAST_MONTH) || (days[8:0] < {4'b0, mlen});

  always_ff @(posedge clk) begin
    case (op)
      ecal_pkg::OP_LOAD: begin
        acc  <= epoch_seconds;
        yoff <= ecal_pkg::FIRST_YOFF;
        mon  <= '0;
      end
      ecal_pkg::OP_DIV_DAY: days <= day_prod[50:35];
      ecal_pkg::OP_SET_HOUR: begin
        rem <= {tod_hi[9:0], acc[6:0]};
        wq  <= wq_prod[32:19];
      end
      ecal_pkg::OP_DIV_HOUR: begin
        hr <= hr_prod[25:21];
        wd <= wrem[2:0];
      end
      ecal_pkg::OP_SET_MIN: rem <= rem - hback;
      ecal_pkg::OP_DIV_MIN: mn <= mn_prod[19:14];
      ecal_pkg::OP_SET_YEAR: sc <= sdiff[5:0];
      ecal_pkg::OP_YEAR: begin
        if (!status.year_done) begin
          days <= days - {7'b0, ylen};
          yoff <= yoff + 8'd1;
        end
      end
      ecal_pkg::OP_SET_MONTH: yday <= days[8:0];
      ecal_pkg::OP_MONTH: begin
        if (!status.month_done) begin
          days <= days - {11'b0, mlen};
          mon  <= mon + 4'd1;
        end
      end
      ecal_pkg::OP_CAPTURE: begin
        second           <= sc;
        minute           <= mn;
        hour             <= hr;
        weekday          <= wd;
        years_since_1900 <= yoff;
        day_of_year      <= yday;
        month_index      <= mon;
        day_of_month     <= days[4:0] + 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: tb/sv/calendar_checker.sv
// Checker: predicts the UTC calendar word for each accepted epoch word and compares
module calendar_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] epoch_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  second,
  input  logic [5:0]  minute,
  input  logic [4:0]  hour,
  input  logic [2:0]  weekday,
  input  logic [7:0]  years_since_1900,
  input  logic [8:0]  day_of_year,
  input  logic [3:0]  month_index,
  input  logic [4:0]  day_of_month,
  output int          mismatches,
  output int          pending
);

  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned HOUR_SECS = 3600;
  localparam int unsigned MIN_SECS  = 60;
  localparam int unsigned WEEK_DAYS = 7;
  localparam int unsigned EPOCH_YEAR = 1970;
  localparam int unsigned YEAR_BIAS  = 1900;
  localparam int unsigned EPOCH_WEEKDAY = 4; // Jan 1 1970 fell on a Thursday
  localparam int unsigned DECEMBER = 11;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
  } calendar_t;

  // conversions accepted but not yet delivered, oldest first
  calendar_t calendar_q[$];

  // full Gregorian rule on the calendar year
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input bit leap, input int unsigned m);
    case (m)
      1:           return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // broken-down UTC time of an epoch count
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned tod;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    bit          leap;
    tod  = secs % DAY_SECS;
    days = secs / DAY_SECS;
    c.second  = 6'(tod % MIN_SECS);
    c.minute  = 6'((tod % HOUR_SECS) / MIN_SECS);
    c.hour    = 5'(tod / HOUR_SECS);
    c.weekday = 3'((days + EPOCH_WEEKDAY) % WEEK_DAYS);
    // strip whole years
    yr = EPOCH_YEAR;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days = days - (leap_year(yr) ? 366 : 365);
      yr++;
    end
    c.years_since_1900 = 8'(yr - YEAR_BIAS);
    c.day_of_year = 9'(days);
    // strip whole months; December takes whatever is left
    leap = leap_year(yr);
    mon = 0;
    while (mon < DECEMBER && days >= days_in_month(leap, mon)) begin
      days = days - days_in_month(leap, mon);
      mon++;
    end
    c.month_index  = 4'(mon);
    c.day_of_month = 5'(days + 1);
    return c;
  endfunction

  function automatic int field_bad(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // watch both channels; predict on accept, compare on delivery
  always @(posedge clk) begin
    calendar_t want;
    int        bad;
    if (rst) begin
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && in_ready)
        calendar_q.push_back(calendar_of(epoch_seconds));
      if (out_valid && out_ready) begin
        if (calendar_q.size() == 0) begin
          $error("calendar word delivered with no conversion outstanding");
          mismatches <= mismatches + 1;
        end else begin
          want = calendar_q.pop_front();
          bad  = field_bad("second", int'(want.second), int'(second))
               + field_bad("minute", int'(want.minute), int'(minute))
               + field_bad("hour", int'(want.hour), int'(hour))
               + field_bad("weekday", int'(want.weekday), int'(weekday))
               + field_bad("years_since_1900", int'(want.years_since_1900),
                           int'(years_since_1900))
               + field_bad("day_of_year", int'(want.day_of_year), int'(day_of_year))
               + field_bad("month_index", int'(want.month_index), int'(month_index))
               + field_bad("day_of_month", int'(want.day_of_month), int'(day_of_month));
          mismatches <= mismatches + bad;
        end
      end
      pending <= calendar_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top: drives epoch words, stalls the result side and reports the verdict
module tb;

  localparam int PHASES = 4;
  localparam int PHASE_WORDS = 450;
  localparam int CORNERS = 24;
  localparam int DRAIN_CYCLES = 200;
  localparam longint unsigned DAY_SECS = 86400;
  localparam longint unsigned EPOCH_MAX = 64'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;
  logic [7:0]  years_since_1900;
  logic [8:0]  day_of_year;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;
  int          mismatches;
  int          pending;

  // idle percentages per phase: none, sender, receiver, both
  int sender_idle_pct[PHASES] = '{0, 65, 0, 13};
  int ready_stall_pct[PHASES] = '{0, 0, 65, 13};
  int sender_idle = 0;
  int ready_stall = 0;

  // day, year, leap-day, century and range-end edges
  logic [31:0] corner_secs[CORNERS] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399,
    32'd946684799, 32'd946684800, 32'd951782400, 32'd978307199,
    32'd2147483647, 32'd2147483648, 32'd4102444799, 32'd4102444800,
    32'd4107456000, 32'd4107542400, 32'd4133980799, 32'hFFFF_FFFF
  };

  always #6 clk = ~clk;

  epoch_seconds_to_calendar dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .epoch_seconds(epoch_seconds),
    .out_valid(out_valid), .out_ready(out_ready),
    .second(second), .minute(minute), .hour(hour), .weekday(weekday),
    .years_since_1900(years_since_1900), .day_of_year(day_of_year),
    .month_index(month_index), .day_of_month(day_of_month)
  );

  calendar_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .epoch_seconds(epoch_seconds),
    .out_valid(out_valid), .out_ready(out_ready),
    .second(second), .minute(minute), .hour(hour), .weekday(weekday),
    .years_since_1900(years_since_1900), .day_of_year(day_of_year),
    .month_index(month_index), .day_of_month(day_of_month),
    .mismatches(mismatches), .pending(pending)
  );

  // result side backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= ready_stall);
  end

  // present one epoch word and hold it until taken; valid stays up afterwards
  task automatic send_epoch(input logic [31:0] secs);
    while ($urandom_range(0, 99) < sender_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
  endtask

  // random epoch: anywhere, near a midnight, or near a New Year
  task automatic send_random_epoch();
    longint unsigned secs;
    longint unsigned jan1;
    int unsigned     yr;
    int unsigned     y;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: secs = $urandom();
      4, 5, 6: begin
        secs = longint'($urandom_range(0, 49709)) * DAY_SECS;
        if ($urandom_range(0, 1))
          secs = secs + DAY_SECS - $urandom_range(1, 3);
        else
          secs = secs + $urandom_range(0, 2);
      end
      default: begin
        yr = $urandom_range(1971, 2106);
        jan1 = 0;
        for (y = 1970; y < yr; y++)
          jan1 += ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 366 * DAY_SECS
                                                                      : 365 * DAY_SECS;
        // within two days either side of January 1
        secs = jan1 - 2 * DAY_SECS + $urandom_range(0, 4 * DAY_SECS - 1);
      end
    endcase
    if (secs > EPOCH_MAX)
      secs = EPOCH_MAX;
    send_epoch(secs[31:0]);
  endtask

  // stimulus and verdict
  initial begin
    int p;
    int n;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (corner_secs[i])
      send_epoch(corner_secs[i]);

    for (p = 0; p < PHASES; p++) begin
      sender_idle = sender_idle_pct[p];
      ready_stall = ready_stall_pct[p];
      for (n = 0; n < PHASE_WORDS; n++)
        send_random_epoch();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
